FILE: design/avt_pkg.sv
// ---------------------------------------------------------------------------
// avt_pkg
// Shared types and constants of the affine vertex transform stack.
// ---------------------------------------------------------------------------
`default_nettype none
package avt_pkg;

   localparam int unsigned CoefWidth = 32;
   localparam int unsigned PixWidth  = 16;

   typedef enum logic [2:0] {
      OP_BEGIN  = 3'd0,
      OP_PUSH   = 3'd1,
      OP_POP    = 3'd2,
      OP_MULT   = 3'd3,
      OP_VERTEX = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
      logic signed [31:0] coef_d;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               point_valid;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
   } mat_type;

   // Classified command handed from front to back.
   typedef struct packed {
      logic               is_begin;
      logic               is_push;
      logic               is_pop;
      logic               is_mult;
      logic               is_vertex;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } cmd_type;

endpackage
`default_nettype wire

FILE: design/avt_ram.sv
// ---------------------------------------------------------------------------
// avt_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module avt_ram #(
   parameter int unsigned WIDTH = 192,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: design/avt_front.sv
// ---------------------------------------------------------------------------
// avt_front
// Decodes the op code into a command and queues it for the back part.
// ---------------------------------------------------------------------------
`default_nettype none
module avt_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire avt_pkg::req_type req,
   output logic                  cmd_valid,
   input  wire logic             cmd_take,
   output avt_pkg::cmd_type      cmd
);
   // two-entry queue
   avt_pkg::cmd_type q_ff [2];
   avt_pkg::cmd_type new_cmd;
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             acc;

   always_comb begin
      new_cmd.is_begin  = (req.op == avt_pkg::OP_BEGIN);
      new_cmd.is_push   = (req.op == avt_pkg::OP_PUSH);
      new_cmd.is_pop    = (req.op == avt_pkg::OP_POP);
      new_cmd.is_mult   = (req.op == avt_pkg::OP_MULT);
      new_cmd.is_vertex = (req.op == avt_pkg::OP_VERTEX);
      new_cmd.a = req.coef_a;
      new_cmd.b = req.coef_b;
      new_cmd.c = req.coef_c;
      new_cmd.d = req.coef_d;
      new_cmd.x = req.pos_x;
      new_cmd.y = req.pos_y;
   end

   assign full      = (cnt_ff == 2'd2);
   assign acc       = push && !full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ acc;
      rd_ptr_in = rd_ptr_ff ^ (cmd_take && cmd_valid);
      cnt_in    = cnt_ff + {1'b0, acc} - {1'b0, cmd_take && cmd_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (acc) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end
endmodule
`default_nettype wire

FILE: design/avt_back.sv
// ---------------------------------------------------------------------------
// avt_back
// Executes commands: matrix state, stack, transform, output queue.
// ---------------------------------------------------------------------------
`default_nettype none
module avt_back #(
   parameter int unsigned STACK_DEPTH = 16,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   output logic                  cmd_take,
   input  wire avt_pkg::cmd_type cmd,
   output logic                  empty,
   input  wire logic             pop,
   output avt_pkg::rsp_type      rsp
);
   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned PW = 64;
   localparam int unsigned SW = 67;
   localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

   // Pipeline: S0 issue (reads stack, multiplies), S1 sum/round, commit.
   // A multiply or pop changes the matrix at the end of S1, so S0 holds
   // while S1 carries one of those.
   avt_pkg::mat_type cur_ff, cur_in;
   logic [LW-1:0]    lvl_ff, lvl_in;
   logic             hp_ff, hp_in;
   logic signed [15:0] lx_ff, ly_ff, lx_in, ly_in;

   // S1 registers
   logic             s1_v_ff;
   avt_pkg::cmd_type s1_c_ff;
   logic [1:0]       s1_st_ff;
   logic signed [PW-1:0] p_ff [6];
   logic signed [PW-1:0] tp_ff [4];

   // output queue, 4 entries (covers in-flight items)
   avt_pkg::rsp_type oq_ff [4];
   logic [1:0] ow_ff, or_ff;
   logic [2:0] ocnt_ff, ocnt_in;
   logic       o_wr;
   avt_pkg::rsp_type o_data;

   logic [191:0] rd_data;
   logic         mem_wr;
   logic [AW-1:0] wr_addr, rd_addr;
   logic         push_ok, pop_ok;
   logic         hazard, issue;
   logic [1:0]   st0;

   assign push_ok = (lvl_ff < LW'(STACK_DEPTH));
   assign pop_ok  = (lvl_ff != '0);
   assign hazard  = s1_v_ff && (s1_c_ff.is_mult || s1_c_ff.is_pop);
   assign issue   = cmd_valid && !hazard && (ocnt_ff + {2'b0, s1_v_ff} < 3'd4);
   assign cmd_take = issue;
   assign mem_wr  = issue && cmd.is_push && push_ok;
   assign wr_addr = lvl_ff[AW-1:0];
   assign rd_addr = AW'(lvl_ff - LW'(1));

   always_comb begin
      st0 = avt_pkg::ST_OK;
      if (cmd.is_push && !push_ok) st0 = avt_pkg::ST_OVERFLOW;
      if (cmd.is_pop && !pop_ok)   st0 = avt_pkg::ST_UNDERFLOW;
   end

   avt_ram #(.WIDTH(192), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_addr),
      .wr_data (cur_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // S0: products. Multiply uses (a,b,c,d) rows, vertex/translate (x,y).
   logic signed [31:0] l0, l1, l2, l3;
   always_comb begin
      if (cmd.is_mult) begin
         l0 = cmd.a; l1 = cmd.b; l2 = cmd.c; l3 = cmd.d;
      end else begin
         l0 = cmd.x; l1 = cmd.y; l2 = cmd.x; l3 = cmd.y;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_c_ff  <= cmd;
         s1_st_ff <= st0;
         p_ff[0] <= l0 * cur_ff.a;        // a' / X
         p_ff[1] <= l1 * cur_ff.c;
         p_ff[2] <= l0 * cur_ff.b;        // b' / Y
         p_ff[3] <= l1 * cur_ff.d;
         p_ff[4] <= l2 * cur_ff.a;        // c'
         p_ff[5] <= l3 * cur_ff.c;
         // translation products kept apart: their sum needs more than 64 bits
         tp_ff[0] <= cmd.x * cur_ff.a;
         tp_ff[1] <= cmd.y * cur_ff.c;
         tp_ff[2] <= cmd.x * cur_ff.b;
         tp_ff[3] <= cmd.y * cur_ff.d;
      end
   end

   // d' product needs its own pair
   logic signed [PW-1:0] pd0_ff, pd1_ff;
   always_ff @(posedge clock) begin
      if (issue) begin
         pd0_ff <= l2 * cur_ff.b;
         pd1_ff <= l3 * cur_ff.d;
      end
   end

   function automatic logic signed [31:0] rnd32(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] r;
      r = (s + (SW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > SW'(64'sd2147483647))       return 32'sh7fffffff;
      else if (r < -SW'(64'sd2147483648)) return 32'sh80000000;
      else                                return r[31:0];
   endfunction

   function automatic logic signed [15:0] rnd16(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] r;
      r = (s + (SW'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
      if (r > SW'(32767))        return 16'sh7fff;
      else if (r < -SW'(32768))  return 16'sh8000;
      else                       return r[15:0];
   endfunction

   logic signed [SW-1:0] txs, tys, vxs, vys;
   logic signed [15:0] vx, vy;
   avt_pkg::mat_type prod;
   logic new_pt;

   always_comb begin
      txs = SW'(tp_ff[0]) + SW'(tp_ff[1]) + (SW'(cur_ff.tx) <<< FRAC_BITS);
      tys = SW'(tp_ff[2]) + SW'(tp_ff[3]) + (SW'(cur_ff.ty) <<< FRAC_BITS);
      vxs = SW'(p_ff[0]) + SW'(p_ff[1]) + (SW'(cur_ff.tx) <<< FRAC_BITS);
      vys = SW'(p_ff[2]) + SW'(p_ff[3]) + (SW'(cur_ff.ty) <<< FRAC_BITS);
      vx  = rnd16(vxs);
      vy  = rnd16(vys);
      prod.a  = rnd32(SW'(p_ff[0]) + SW'(p_ff[1]));
      prod.b  = rnd32(SW'(p_ff[2]) + SW'(p_ff[3]));
      prod.c  = rnd32(SW'(p_ff[4]) + SW'(p_ff[5]));
      prod.d  = rnd32(SW'(pd0_ff) + SW'(pd1_ff));
      prod.tx = rnd32(txs);
      prod.ty = rnd32(tys);
      new_pt  = !hp_ff || vx != lx_ff || vy != ly_ff;
   end

   always_comb begin
      cur_in = cur_ff;
      lvl_in = lvl_ff;
      hp_in  = hp_ff;
      lx_in  = lx_ff;
      ly_in  = ly_ff;
      o_data = '0;
      o_data.status = s1_st_ff;
      if (issue && cmd.is_push && push_ok) lvl_in = lvl_ff + LW'(1);
      if (issue && cmd.is_pop && pop_ok)   lvl_in = lvl_ff - LW'(1);
      if (s1_v_ff) begin
         if (s1_c_ff.is_begin) hp_in = 1'b0;
         if (s1_c_ff.is_mult)  cur_in = prod;
         if (s1_c_ff.is_pop && s1_st_ff == avt_pkg::ST_OK) cur_in = rd_data;
         if (s1_c_ff.is_vertex && new_pt) begin
            hp_in = 1'b1;
            lx_in = vx;
            ly_in = vy;
            o_data.point_x = vx;
            o_data.point_y = vy;
            o_data.point_valid = 1'b1;
         end
      end
   end

   assign o_wr  = s1_v_ff;
   assign empty = (ocnt_ff == 3'd0);
   assign rsp   = oq_ff[or_ff];
   assign ocnt_in = ocnt_ff + {2'b0, o_wr} - {2'b0, pop && !empty};

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '{a: One, b: '0, c: '0, d: One, tx: '0, ty: '0};
         lvl_ff  <= '0;
         hp_ff   <= 1'b0;
         lx_ff   <= '0;
         ly_ff   <= '0;
         s1_v_ff <= 1'b0;
         ow_ff   <= '0;
         or_ff   <= '0;
         ocnt_ff <= '0;
      end else begin
         cur_ff  <= cur_in;
         lvl_ff  <= lvl_in;
         hp_ff   <= hp_in;
         lx_ff   <= lx_in;
         ly_ff   <= ly_in;
         s1_v_ff <= issue;
         ow_ff   <= ow_ff + 2'(o_wr);
         or_ff   <= or_ff + 2'(pop && !empty);
         ocnt_ff <= ocnt_in;
      end
      if (o_wr) begin
         oq_ff[ow_ff] <= o_data;
      end
   end
endmodule
`default_nettype wire

FILE: design/affine_vertex_transform_stack_top.sv
// ---------------------------------------------------------------------------
// affine_vertex_transform_stack_top
// 2D affine matrix stack and vertex transform engine, Q fixed point.
// ---------------------------------------------------------------------------
//  channel  | ports                   | direction
//  request  | req_push, req_full, req | in  (one command item)
//  response | rsp_empty, rsp_pop, rsp | out (one result item per command)
//
// Begin, push and vertex items stream at one per cycle while the result queue
// has room; multiply and pop hold issue of the next item while they are in
// the sum/round stage, as the next item needs the matrix they commit.
// Synchronous reset loads the identity matrix and empties the stack; stack
// contents are not cleared. Either side may stall freely: a 2-entry command
// queue and a 4-entry result queue part the two.
`default_nettype none
module affine_vertex_transform_stack_top #(
   parameter int unsigned STACK_DEPTH = 16,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire avt_pkg::req_type req,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output avt_pkg::rsp_type      rsp
);
   logic             cmd_valid, cmd_take;
   avt_pkg::cmd_type cmd;

   avt_front u_front (
      .clock, .reset,
      .push      (req_push),
      .full      (req_full),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd)
   );

   avt_back #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset,
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .rsp       (rsp)
   );
endmodule
`default_nettype wire

FILE: design/avt_checker.sv
// ---------------------------------------------------------------------------
// avt_checker
// Port-level checks on the affine vertex transform stack.
// ---------------------------------------------------------------------------
`default_nettype none
module avt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_full,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire avt_pkg::rsp_type rsp
);
   a_empty_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");
   a_full_reset: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input blocked after reset");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp.status <= avt_pkg::ST_UNDERFLOW))
      else $error("bad status");
   a_point_only_ok: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp.point_valid) |-> rsp.status == avt_pkg::ST_OK)
      else $error("point with error status");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp)))
      else $error("result changed while waiting");
endmodule

bind affine_vertex_transform_stack_top avt_checker u_avt_checker (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp
);
`default_nettype wire

FILE: tb/affine_vertex_transform_stack_top_tb.sv
// ---------------------------------------------------------------------------
// affine_vertex_transform_stack_top_tb
// Self-checking bench for the affine vertex transform stack: directed and
// random command streams, scoreboard prediction, random idling on both sides.
// ---------------------------------------------------------------------------
`default_nettype none

// Predicts one result per command from its own copy of the matrix and stack.
class transform_scoreboard;
   logic signed [31:0] m_a, m_b, m_c, m_d, m_tx, m_ty;
   logic signed [31:0] sv_a[16], sv_b[16], sv_c[16], sv_d[16], sv_tx[16], sv_ty[16];
   int unsigned        depth;
   logic signed [15:0] prev_x, prev_y;
   bit                 have_prev;
   avt_pkg::rsp_type   expected_q[$];
   int                 mismatches;

   function new();
      m_a = 32'sh10000; m_d = 32'sh10000;
      m_b = 0; m_c = 0; m_tx = 0; m_ty = 0;
      depth = 0; prev_x = 0; prev_y = 0; have_prev = 0; mismatches = 0;
   endfunction

   // floor((s + 2^(sh-1)) / 2^sh) on a wide exact sum
   static function logic signed [79:0] round_shift(logic signed [79:0] s, int sh);
      logic signed [79:0] t;
      t = s + (80'sd1 <<< (sh - 1));
      return t >>> sh;
   endfunction

   static function logic signed [31:0] sat32(logic signed [79:0] v);
      if (v > 80'sd2147483647) return 32'sh7fffffff;
      if (v < -80'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   static function logic signed [15:0] sat16(logic signed [79:0] v);
      if (v > 80'sd32767) return 16'sh7fff;
      if (v < -80'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   static function logic signed [79:0] dot3(logic signed [31:0] p, logic signed [31:0] q,
                                             logic signed [31:0] r, logic signed [31:0] s,
                                             logic signed [31:0] t);
      logic signed [79:0] acc;
      acc = 80'(p) * 80'(q) + 80'(r) * 80'(s) + (80'(t) <<< 16);
      return acc;
   endfunction

   function void note_command(avt_pkg::req_type it);
      avt_pkg::rsp_type   res;
      logic signed [31:0] na, nb, nc, nd, nx, ny;
      logic signed [15:0] vx, vy;
      res = '0;
      case (it.op)
         avt_pkg::OP_BEGIN: have_prev = 0;
         avt_pkg::OP_PUSH: begin
            if (depth >= 16) res.status = avt_pkg::ST_OVERFLOW;
            else begin
               sv_a[depth] = m_a; sv_b[depth] = m_b; sv_c[depth] = m_c;
               sv_d[depth] = m_d; sv_tx[depth] = m_tx; sv_ty[depth] = m_ty;
               depth++;
            end
         end
         avt_pkg::OP_POP: begin
            if (depth == 0) res.status = avt_pkg::ST_UNDERFLOW;
            else begin
               depth--;
               m_a = sv_a[depth]; m_b = sv_b[depth]; m_c = sv_c[depth];
               m_d = sv_d[depth]; m_tx = sv_tx[depth]; m_ty = sv_ty[depth];
            end
         end
         avt_pkg::OP_MULT: begin
            na = sat32(round_shift(dot3(it.coef_a, m_a, it.coef_b, m_c, 0), 16));
            nb = sat32(round_shift(dot3(it.coef_a, m_b, it.coef_b, m_d, 0), 16));
            nc = sat32(round_shift(dot3(it.coef_c, m_a, it.coef_d, m_c, 0), 16));
            nd = sat32(round_shift(dot3(it.coef_c, m_b, it.coef_d, m_d, 0), 16));
            nx = sat32(round_shift(dot3(it.pos_x, m_a, it.pos_y, m_c, m_tx), 16));
            ny = sat32(round_shift(dot3(it.pos_x, m_b, it.pos_y, m_d, m_ty), 16));
            m_a = na; m_b = nb; m_c = nc; m_d = nd; m_tx = nx; m_ty = ny;
         end
         avt_pkg::OP_VERTEX: begin
            vx = sat16(round_shift(dot3(it.pos_x, m_a, it.pos_y, m_c, m_tx), 32));
            vy = sat16(round_shift(dot3(it.pos_x, m_b, it.pos_y, m_d, m_ty), 32));
            if (!have_prev || vx != prev_x || vy != prev_y) begin
               prev_x = vx; prev_y = vy; have_prev = 1;
               res.point_x = vx; res.point_y = vy; res.point_valid = 1;
            end
         end
         default: ;
      endcase
      expected_q.push_back(res);
   endfunction

   function void check_result(avt_pkg::rsp_type got);
      avt_pkg::rsp_type want;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      want = expected_q.pop_front();
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.point_valid !== want.point_valid || got.status !== want.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: expected x=%0d y=%0d v=%0b st=%0d,",
                      " got x=%0d y=%0d v=%0b st=%0d"},
                     want.point_x, want.point_y, want.point_valid, want.status,
                     got.point_x, got.point_y, got.point_valid, got.status);
      end
   endfunction
endclass

module affine_vertex_transform_stack_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_push = 0;
   logic             req_full;
   avt_pkg::req_type req = '0;
   logic             rsp_empty;
   logic             rsp_pop = 0;
   avt_pkg::rsp_type rsp;

   transform_scoreboard sb = new();

   // idle percentages per phase, and a long hold on the result side
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_cycles = 0;
   bit  done = 0;
   int  quiet_cycles = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   affine_vertex_transform_stack_top i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req(req),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp(rsp)
   );

   // Result side: sample at the edge, then choose the next pop level.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) sb.check_result(rsp);
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_pop <= 0;
         end else
            rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: cycles with nothing accepted on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WatchdogLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Offer one item, with random idle cycles ahead of it; wait for acceptance.
   // push stays high after acceptance until the next idle cycle or item.
   task automatic send_item(avt_pkg::req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(posedge clock);
      end
      req <= it;
      req_push <= 1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_command(it);
   endtask

   task automatic wait_drained();
      req_push <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return 32'($signed($urandom_range(131072)) - 65536);
         default: return 32'($signed($urandom_range(1024)) - 512) << $urandom_range(6, 16);
      endcase
   endfunction

   function automatic avt_pkg::req_type make_item(logic [2:0] op);
      avt_pkg::req_type it;
      it.op = op;
      it.coef_a = rand_coef(); it.coef_b = rand_coef();
      it.coef_c = rand_coef(); it.coef_d = rand_coef();
      it.pos_x = rand_coef(); it.pos_y = rand_coef();
      return it;
   endfunction

   // Weighted random mix: mostly vertices, with begin, push, mult, pop and rare undefined op codes.
   task automatic send_random(int count);
      avt_pkg::req_type it;
      int               pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 6) it = make_item(avt_pkg::OP_BEGIN);
         else if (pick < 16) it = make_item(avt_pkg::OP_PUSH);
         else if (pick < 26) it = make_item(avt_pkg::OP_POP);
         else if (pick < 36) it = make_item(avt_pkg::OP_MULT);
         else if (pick < 97) it = make_item(avt_pkg::OP_VERTEX);
         else it = make_item(3'($urandom_range(5, 7)));
         // vertex repeats exercise duplicate suppression
         if (it.op == avt_pkg::OP_VERTEX && $urandom_range(3) == 0) it.pos_x = req.pos_x;
         if (it.op == avt_pkg::OP_VERTEX && $urandom_range(3) == 0) it.pos_y = req.pos_y;
         // keep the matrix usable: half of the multiplies use coefficients within -1.0 to 1.0 (Q16.16)
         if (it.op == avt_pkg::OP_MULT && $urandom_range(1) == 0) begin
            it.coef_a = 32'($signed($urandom_range(131072)) - 65536);
            it.coef_b = 32'($signed($urandom_range(131072)) - 65536);
            it.coef_c = 32'($signed($urandom_range(131072)) - 65536);
            it.coef_d = 32'($signed($urandom_range(131072)) - 65536);
         end
         send_item(it);
      end
   endtask

   initial begin
      avt_pkg::req_type it;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: underflow, vertex through identity, duplicate, begin, extremes.
      send_item(make_item(avt_pkg::OP_POP));
      it = '0; it.op = avt_pkg::OP_VERTEX;
      it.pos_x = 32'sh00018000; it.pos_y = -32'sh00018000;
      send_item(it);
      send_item(it);                                   // duplicate
      send_item(make_item(avt_pkg::OP_BEGIN));
      send_item(it);                                   // same point after begin
      it.pos_x = 32'sh7fffffff; it.pos_y = 32'sh80000000;
      send_item(it);                                   // saturates
      send_item(make_item(avt_pkg::OP_PUSH));
      it = '0; it.op = avt_pkg::OP_MULT;
      it.coef_a = 32'sh7fffffff; it.coef_b = 32'sh7fffffff;
      it.coef_c = 32'sh80000000; it.coef_d = 32'sh80000000;
      it.pos_x = 32'sh7fffffff; it.pos_y = 32'sh80000000;
      send_item(it);
      send_item(make_item(avt_pkg::OP_VERTEX));
      send_item(make_item(avt_pkg::OP_POP));
      repeat (17) send_item(make_item(avt_pkg::OP_PUSH));   // last one overflows
      repeat (17) send_item(make_item(avt_pkg::OP_POP));    // last one underflows
      for (int k = 5; k < 8; k++) send_item(make_item(3'(k)));
      send_item(make_item(avt_pkg::OP_MULT));
      wait_drained();

      send_idle_pct = 0;  recv_stall_pct = 0;  send_random(300);
      // long receiver hold while the sender keeps offering items
      hold_cycles = 60;
      send_random(40);
      // sender pauses until everything is back
      wait_drained();
      send_idle_pct = 83; recv_stall_pct = 0;  send_random(300);
      send_idle_pct = 0;  recv_stall_pct = 83; send_random(300);
      send_idle_pct = 12; recv_stall_pct = 12; send_random(300);
      send_idle_pct = 0;  recv_stall_pct = 0;  send_random(60);

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

`default_nettype wire
